// ===== rtl/core/mcspc_pkg.sv =====
// Shared constants, codes and types of the image checker page CRC block.
package mcspc_pkg;

	// Geometry and reset values
	localparam int unsigned PAGE_BYTES_DEF   = 256;
	localparam int unsigned ROOM_W           = 9;
	localparam logic [7:0]  START_SECTOR_RST = 8'h00;
	localparam logic [7:0]  CRC_POLY_RST     = 8'h09;
	localparam logic [7:0]  PAD_BYTE         = 8'hFF;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SECTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY     = 1'b1;

	// Item kinds and record types
	localparam logic       REQ_HEADER = 1'b0;
	localparam logic       REQ_DATA   = 1'b1;
	localparam logic [7:0] REC_DATA   = 8'h00;
	localparam logic [7:0] REC_EOF    = 8'h01;
	localparam logic [7:0] REC_EXT    = 8'h04;

	// Status codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_SECTOR  = 3'd1;
	localparam logic [2:0] ERR_ADDR    = 3'd2;
	localparam logic [2:0] ERR_TYPE    = 3'd3;
	localparam logic [2:0] ERR_OVERRUN = 3'd4;
	localparam logic [2:0] ERR_STRAY   = 3'd5;

	typedef struct packed {
		logic       req_type;
		logic [7:0] record_type;
		logic [7:0] sector;
		logic [7:0] page;
		logic [7:0] byte_offset;
		logic [7:0] byte_count;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] crc;
		logic       page_done;
		logic       image_done;
		logic [7:0] current_sector;
	} result_t;

	typedef struct packed {
		logic       start_we;
		logic [7:0] start_sector;
		logic [7:0] crc_poly;
	} cfg_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_PAD,
		SEQ_RESP
	} seq_state_t;

endpackage

// ===== rtl/core/mcspc_if.sv =====
// Valid/ready channel interfaces for record items and check results.
interface mcspc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] record_type;
	logic [7:0] sector;
	logic [7:0] page;
	logic [7:0] byte_offset;
	logic [7:0] byte_count;
	logic [7:0] data_byte;

	modport source (
		output valid, req_type, record_type, sector, page, byte_offset, byte_count, data_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, record_type, sector, page, byte_offset, byte_count, data_byte,
		output ready
	);
endinterface

interface mcspc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] crc;
	logic       page_done;
	logic       image_done;
	logic [7:0] current_sector;

	modport source (
		output valid, status, crc, page_done, image_done, current_sector,
		input  ready
	);
	modport sink (
		input  valid, status, crc, page_done, image_done, current_sector,
		output ready
	);
endinterface

// ===== rtl/core/mcs_image_checker_page_crc_core.sv =====
// Top level of the flash image record checker with per-page CRC-8.
//
// Usage:
//   req carries decoded hex records: a header transfer (req_type 0) and, for a
//   data record, its payload bytes one transfer each (req_type 1). rsp returns
//   exactly one result per request: sticky status, CRC over completed pages,
//   page_done, image_done and the sector now expected.
//   The config port (cfg_we, cfg_index, cfg_wdata) writes start_sector
//   (index 0) and the CRC polynomial low byte (index 1); write only when idle.
// Timing and throughput:
//   Headers and data bytes are handled in the cycle of their transfer, data
//   bytes through the shared byte CRC unit; the result is registered and
//   shows on rsp in the next cycle, so one item per cycle is sustained while
//   rsp takes each result. An end record that closes an open page runs the
//   same CRC unit once per pad byte (PAGE_BYTES - offset of them), then posts
//   the result from a response state; req is not ready meanwhile.
// Reset:
//   arst_n clears order state, CRC and error; registers return to defaults.
// Back-pressure:
//   A single output register holds the result; a new request is taken while
//   it waits only if rsp takes it in the same cycle, otherwise req stalls.
module mcs_image_checker_page_crc_core #(
	parameter int unsigned PAGE_BYTES = mcspc_pkg::PAGE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mcspc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcspc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	mcspc_req_if.sink                           req,
	mcspc_rsp_if.source                         rsp
);

	logic [7:0]         crc_poly_q;
	mcspc_pkg::cfg_t    cfg;
	mcspc_pkg::item_t   item;
	mcspc_pkg::result_t res;
	mcspc_pkg::result_t res_q;
	logic               res_load;
	logic               out_valid_q;
	logic               out_free;
	logic               item_ready;

	// Configuration registers; start_sector goes straight to the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= mcspc_pkg::CRC_POLY_RST;
		end else if (cfg_we) begin
			if (cfg_index == mcspc_pkg::CFG_CRC_POLY) begin
				crc_poly_q <= cfg_wdata;
			end
		end
	end

	assign cfg.start_we     = cfg_we && (cfg_index == mcspc_pkg::CFG_START_SECTOR);
	assign cfg.start_sector = cfg_wdata;
	assign cfg.crc_poly     = crc_poly_q;

	// Request payload
	assign item.req_type    = req.req_type;
	assign item.record_type = req.record_type;
	assign item.sector      = req.sector;
	assign item.page        = req.page;
	assign item.byte_offset = req.byte_offset;
	assign item.byte_count  = req.byte_count;
	assign item.data_byte   = req.data_byte;
	assign req.ready        = item_ready;

	mcspc_seq #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.item_valid (req.valid),
		.item_ready (item_ready),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res)
	);

	// Output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = res_q.status;
	assign rsp.crc            = res_q.crc;
	assign rsp.page_done      = res_q.page_done;
	assign rsp.image_done     = res_q.image_done;
	assign rsp.current_sector = res_q.current_sector;

endmodule

// ===== rtl/core/mcspc_crc_unit.sv =====
// Shared byte-wide CRC-8 step unit, MSB first, programmable polynomial.
module mcspc_crc_unit (
	input  logic [7:0] rem,
	input  logic [7:0] data,
	input  logic [7:0] poly,
	output logic [7:0] crc
);

	// Eight bit steps of the shift register over one byte
	always_comb begin
		logic [7:0] r;
		r = rem ^ data;
		for (int k = 0; k < 8; k++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ poly;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		crc = r;
	end

endmodule

// ===== rtl/core/mcspc_seq.sv =====
// Order checker and sequencer around the shared CRC unit, with page padding.
module mcspc_seq #(
	parameter int unsigned PAGE_BYTES = mcspc_pkg::PAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcspc_pkg::cfg_t     cfg,
	input  mcspc_pkg::item_t    item,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                out_free,
	output logic                res_load,
	output mcspc_pkg::result_t  res
);

	localparam int unsigned EBW  = $clog2(PAGE_BYTES);
	localparam int unsigned CNTW = $clog2(PAGE_BYTES + 1);
	localparam int unsigned RW   = mcspc_pkg::ROOM_W;

	mcspc_pkg::seq_state_t state_q, state_d;

	logic [7:0]      sector_q, sector_d;
	logic [7:0]      page_q, page_d;
	logic [EBW-1:0]  byte_q, byte_d;
	logic            pending_q, pending_d;
	logic [7:0]      crc_value_q, crc_value_d;
	logic [7:0]      work_crc_q, work_crc_d;
	logic [7:0]      left_q, left_d;
	logic            latched_q, latched_d;
	logic [2:0]      code_q, code_d;
	logic            started_q, started_d;
	logic [CNTW-1:0] pad_cnt_q, pad_cnt_d;

	logic [2:0]      err;
	logic            pdone;
	logic            idone;
	logic [7:0]      crc_data;
	logic [7:0]      crc_out;
	logic [CNTW-1:0] byte_inc;
	logic            byte_wrap;
	logic [CNTW-1:0] pad_len;
	logic [RW-1:0]   room;

	// Shared CRC step: payload byte when idle, pad byte while padding
	mcspc_crc_unit u_crc (
		.rem  (work_crc_q),
		.data (crc_data),
		.poly (cfg.crc_poly),
		.crc  (crc_out)
	);

	// Address arithmetic within the page
	assign byte_inc  = CNTW'(byte_q) + CNTW'(1);
	assign byte_wrap = (byte_inc == CNTW'(PAGE_BYTES));
	assign pad_len   = CNTW'(PAGE_BYTES) - CNTW'(byte_q);
	assign room      = RW'(PAGE_BYTES) - RW'(byte_q);

	// Next state and result
	always_comb begin
		state_d     = state_q;
		sector_d    = sector_q;
		page_d      = page_q;
		byte_d      = byte_q;
		pending_d   = pending_q;
		crc_value_d = crc_value_q;
		work_crc_d  = work_crc_q;
		left_d      = left_q;
		latched_d   = latched_q;
		code_d      = code_q;
		started_d   = started_q;
		pad_cnt_d   = pad_cnt_q;
		err         = mcspc_pkg::ERR_NONE;
		pdone       = 1'b0;
		idone       = 1'b0;
		res_load    = 1'b0;
		item_ready  = 1'b0;
		crc_data    = item.data_byte;

		case (state_q)
			mcspc_pkg::SEQ_IDLE: begin
				item_ready = out_free;
				if (cfg.start_we && !started_q) begin
					sector_d = cfg.start_sector;
				end
				if (item_valid && out_free) begin
					res_load = 1'b1;
					if (!latched_q) begin
						started_d = 1'b1;
						if (item.req_type == mcspc_pkg::REQ_HEADER) begin
							// a new header drops any payload still owed
							left_d = '0;
							case (item.record_type)
								mcspc_pkg::REC_EXT: begin
									if (item.sector != sector_q || pending_q) begin
										err = mcspc_pkg::ERR_SECTOR;
									end else begin
										page_d = '0;
										byte_d = '0;
									end
								end
								mcspc_pkg::REC_DATA: begin
									if (item.page != page_q || item.byte_offset != 8'(byte_q)) begin
										err = mcspc_pkg::ERR_ADDR;
									end else if (RW'(item.byte_count) > room) begin
										err = mcspc_pkg::ERR_OVERRUN;
									end else if (item.byte_count != 8'd0) begin
										if (!pending_q) begin
											work_crc_d = crc_value_q;
										end
										pending_d = 1'b1;
										left_d    = item.byte_count;
									end
								end
								mcspc_pkg::REC_EOF: begin
									idone = 1'b1;
									// unfinished page: pad it before answering
									if (pending_q) begin
										pad_cnt_d = pad_len;
										state_d   = mcspc_pkg::SEQ_PAD;
										res_load  = 1'b0;
									end
								end
								default: begin
									err = mcspc_pkg::ERR_TYPE;
								end
							endcase
						end else begin
							if (left_q == 8'd0) begin
								err = mcspc_pkg::ERR_STRAY;
							end else begin
								work_crc_d = crc_out;
								left_d     = left_q - 8'd1;
								if (byte_wrap) begin
									crc_value_d = crc_out;
									pending_d   = 1'b0;
									pdone       = 1'b1;
									byte_d      = '0;
									page_d      = page_q + 8'd1;
									if (page_q == 8'hFF) begin
										sector_d = sector_q + 8'd1;
									end
								end else begin
									byte_d = byte_inc[EBW-1:0];
								end
							end
						end
						if (err != mcspc_pkg::ERR_NONE) begin
							latched_d = 1'b1;
							code_d    = err;
							pdone     = 1'b0;
							idone     = 1'b0;
						end
					end
				end
			end
			mcspc_pkg::SEQ_PAD: begin
				crc_data   = mcspc_pkg::PAD_BYTE;
				work_crc_d = crc_out;
				pad_cnt_d  = pad_cnt_q - CNTW'(1);
				if (pad_cnt_q == CNTW'(1)) begin
					crc_value_d = crc_out;
					pending_d   = 1'b0;
					state_d     = mcspc_pkg::SEQ_RESP;
				end
			end
			mcspc_pkg::SEQ_RESP: begin
				pdone = 1'b1;
				idone = 1'b1;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = mcspc_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = mcspc_pkg::SEQ_IDLE;
			end
		endcase

		res.status         = latched_d ? code_d : mcspc_pkg::ERR_NONE;
		res.crc            = crc_value_d;
		res.page_done      = pdone;
		res.image_done     = idone;
		res.current_sector = sector_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcspc_pkg::SEQ_IDLE;
			sector_q    <= mcspc_pkg::START_SECTOR_RST;
			page_q      <= '0;
			byte_q      <= '0;
			pending_q   <= 1'b0;
			crc_value_q <= '0;
			work_crc_q  <= '0;
			left_q      <= '0;
			latched_q   <= 1'b0;
			code_q      <= mcspc_pkg::ERR_NONE;
			started_q   <= 1'b0;
			pad_cnt_q   <= '0;
		end else begin
			state_q     <= state_d;
			sector_q    <= sector_d;
			page_q      <= page_d;
			byte_q      <= byte_d;
			pending_q   <= pending_d;
			crc_value_q <= crc_value_d;
			work_crc_q  <= work_crc_d;
			left_q      <= left_d;
			latched_q   <= latched_d;
			code_q      <= code_d;
			started_q   <= started_d;
			pad_cnt_q   <= pad_cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_pad_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mcspc_pkg::SEQ_PAD |-> pad_cnt_q != '0)
		else $error("pad sequence running with zero count");

	a_byte_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		CNTW'(byte_q) < CNTW'(PAGE_BYTES))
		else $error("expected byte outside page");

	a_owed_needs_page: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 8'd0 |-> pending_q)
		else $error("payload owed without an open page");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q |=> latched_q && $stable(code_q))
		else $error("latched error changed");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded into a full output register");
`endif

endmodule
